FILE: rtl/fsa_pkg.sv
package fsa_pkg;

   // default store geometry
   localparam int unsigned MAX_WIDTH_DEFAULT  = 256;
   localparam int unsigned MAX_HEIGHT_DEFAULT = 256;

   // field widths
   localparam int unsigned POS_W       = 17;
   localparam int unsigned COLOR_W     = 24;
   localparam int unsigned SUM_W       = 32;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned SIZE_W      = 9;
   localparam int unsigned WEIGHT_W    = 24;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 24;
   localparam int unsigned CHANNELS    = 3;
   localparam int unsigned FRAC_W      = 16;

   // readout product is clamped to 1.0 in Q0.32 plus one bit
   localparam int unsigned LEVEL_W = SUM_W + 1;

   localparam logic [POS_W-1:0]    POS_ONE              = 17'h10000;
   localparam logic [SIZE_W-1:0]   FRAME_WIDTH_RESET    = 9'd256;
   localparam logic [SIZE_W-1:0]   FRAME_HEIGHT_RESET   = 9'd256;
   localparam logic [WEIGHT_W-1:0] READOUT_WEIGHT_RESET = 24'h010000;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_READOUT_WEIGHT = 2'd2;

   typedef enum logic [1:0] {
      OP_RECORD     = 2'd0,
      OP_ACCUMULATE = 2'd1,
      OP_READ       = 2'd2,
      OP_CLEAR      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_REJECTED = 2'd1,
      STATUS_OUTSIDE  = 2'd2
   } status_type;

   typedef struct packed {
      op_type              operation;
      logic [POS_W-1:0]    raster_x;
      logic [POS_W-1:0]    raster_y;
      logic [COLOR_W-1:0]  red_in;
      logic [COLOR_W-1:0]  green_in;
      logic [COLOR_W-1:0]  blue_in;
      logic [BYTE_W-1:0]   pixel_col;
      logic [BYTE_W-1:0]   pixel_row;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [BYTE_W-1:0]   red_out;
      logic [BYTE_W-1:0]   green_out;
      logic [BYTE_W-1:0]   blue_out;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_WIPE,
      ST_IDLE,
      ST_DECODE,
      ST_FETCH,
      ST_STORE,
      ST_SCALE,
      ST_SEARCH,
      ST_CLEAR,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic latch_item;
      logic decode;
      logic mem_read;
      logic store;
      logic scale;
      logic search;
      logic wipe;
      logic load_result;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   position_bad;
      logic   pixel_outside;
      logic   wipe_last;
      logic   search_last;
   } flags_type;

   typedef logic [255:0][LEVEL_W-1:0] gamma_table_type;

   // Smallest Q0.32 level P with P^5 * 255^11 >= k^11 * 2^160, i.e. the first
   // level whose gamma 2.2 encoding reaches byte k. Worked out at elaboration.
   function automatic gamma_table_type gamma_thresholds();
      gamma_table_type tbl;
      logic [255:0]    c255;
      logic [255:0]    kpow;
      logic [255:0]    rhs;
      logic [255:0]    lo;
      logic [255:0]    hi;
      logic [255:0]    mid;
      logic [255:0]    p5;
      int              i;
      int              k;
      int              it;
      tbl  = '0;
      c255 = 256'd1;
      for (i = 0; i < 11; i++) c255 = c255 * 256'd255;
      for (k = 1; k < 256; k++) begin
         kpow = 256'd1;
         for (i = 0; i < 11; i++) kpow = kpow * 256'(k);
         rhs = kpow << 160;
         lo  = 256'd1;
         hi  = 256'd1 << 32;
         for (it = 0; it < 34; it++) begin
            if (lo < hi) begin
               mid = (lo + hi) >> 1;
               p5  = mid;
               for (i = 0; i < 4; i++) p5 = p5 * mid;
               if (p5 * c255 >= rhs) hi = mid;
               else lo = mid + 256'd1;
            end
         end
         tbl[k] = lo[LEVEL_W-1:0];
      end
      return tbl;
   endfunction

   localparam gamma_table_type GAMMA_THRESHOLD = gamma_thresholds();

endpackage

FILE: rtl/fsa_ctrl.sv
module fsa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  fsa_pkg::flags_type  flags,
   output fsa_pkg::cmd_type    cmd
);

   fsa_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   // output slot can take a result this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fsa_pkg::ST_WIPE: begin
            if (flags.wipe_last) state_in = fsa_pkg::ST_IDLE;
         end
         fsa_pkg::ST_IDLE: begin
            if (req_valid) state_in = fsa_pkg::ST_DECODE;
         end
         fsa_pkg::ST_DECODE: begin
            case (flags.op)
               fsa_pkg::OP_RECORD: begin
                  state_in = flags.position_bad ? fsa_pkg::ST_FINISH : fsa_pkg::ST_STORE;
               end
               fsa_pkg::OP_ACCUMULATE: begin
                  state_in = flags.position_bad ? fsa_pkg::ST_FINISH : fsa_pkg::ST_FETCH;
               end
               fsa_pkg::OP_READ: begin
                  state_in = flags.pixel_outside ? fsa_pkg::ST_FINISH : fsa_pkg::ST_FETCH;
               end
               default: state_in = fsa_pkg::ST_CLEAR;
            endcase
         end
         fsa_pkg::ST_FETCH: begin
            state_in = (flags.op == fsa_pkg::OP_READ) ? fsa_pkg::ST_SCALE : fsa_pkg::ST_STORE;
         end
         fsa_pkg::ST_STORE:  state_in = fsa_pkg::ST_FINISH;
         fsa_pkg::ST_SCALE:  state_in = fsa_pkg::ST_SEARCH;
         fsa_pkg::ST_SEARCH: begin
            if (flags.search_last) state_in = fsa_pkg::ST_FINISH;
         end
         fsa_pkg::ST_CLEAR: begin
            if (flags.wipe_last) state_in = fsa_pkg::ST_FINISH;
         end
         fsa_pkg::ST_FINISH: begin
            if (slot_free) state_in = fsa_pkg::ST_IDLE;
         end
         default: state_in = fsa_pkg::ST_WIPE;
      endcase
   end

   // commands
   always_comb begin
      cmd             = '0;
      req_ready       = (state_ff == fsa_pkg::ST_IDLE);
      cmd.latch_item  = req_ready && req_valid;
      cmd.decode      = (state_ff == fsa_pkg::ST_DECODE);
      cmd.mem_read    = (state_ff == fsa_pkg::ST_FETCH);
      cmd.store       = (state_ff == fsa_pkg::ST_STORE);
      cmd.scale       = (state_ff == fsa_pkg::ST_SCALE);
      cmd.search      = (state_ff == fsa_pkg::ST_SEARCH);
      cmd.wipe        = (state_ff == fsa_pkg::ST_WIPE) || (state_ff == fsa_pkg::ST_CLEAR);
      cmd.load_result = (state_ff == fsa_pkg::ST_FINISH) && slot_free;
   end

   // result valid: set on load, dropped when the beat is taken
   assign rsp_valid_in = cmd.load_result || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fsa_pkg::ST_WIPE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/fsa_datapath.sv
module fsa_datapath #(
   parameter int unsigned MAX_WIDTH  = fsa_pkg::MAX_WIDTH_DEFAULT,
   parameter int unsigned MAX_HEIGHT = fsa_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [fsa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fsa_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  fsa_pkg::req_type                   req_data,
   input  fsa_pkg::cmd_type                   cmd,
   output fsa_pkg::flags_type                 flags,
   output fsa_pkg::rsp_type                   rsp_data
);

   localparam int unsigned COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int unsigned DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned MAP_W   = fsa_pkg::POS_W + fsa_pkg::SIZE_W;
   localparam int unsigned SCALE_W = fsa_pkg::SUM_W + fsa_pkg::WEIGHT_W;
   localparam int unsigned SEARCH_STEPS = fsa_pkg::BYTE_W;
   localparam int unsigned STEP_W  = $clog2(SEARCH_STEPS);
   localparam int unsigned NCH     = fsa_pkg::CHANNELS;
   localparam int unsigned SUM_W   = fsa_pkg::SUM_W;
   localparam int unsigned BYTE_W  = fsa_pkg::BYTE_W;
   localparam int unsigned SIZE_W  = fsa_pkg::SIZE_W;
   localparam int unsigned LEVEL_W = fsa_pkg::LEVEL_W;
   localparam logic [LEVEL_W-1:0] LEVEL_FULL = {1'b1, {SUM_W{1'b0}}};
   localparam logic [BYTE_W-1:0]  BYTE_MAX   = '1;

   typedef logic [NCH-1:0][SUM_W-1:0] sums_type;

   // configuration
   logic [SIZE_W-1:0]            frame_width_ff;
   logic [SIZE_W-1:0]            frame_height_ff;
   logic [fsa_pkg::WEIGHT_W-1:0] readout_weight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= fsa_pkg::FRAME_WIDTH_RESET;
         frame_height_ff   <= fsa_pkg::FRAME_HEIGHT_RESET;
         readout_weight_ff <= fsa_pkg::READOUT_WEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            fsa_pkg::CSR_FRAME_WIDTH:    frame_width_ff    <= csr_write_data[SIZE_W-1:0];
            fsa_pkg::CSR_FRAME_HEIGHT:   frame_height_ff   <= csr_write_data[SIZE_W-1:0];
            fsa_pkg::CSR_READOUT_WEIGHT: readout_weight_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // frame size in use: zero acts as one, oversize as the store limit
   logic [SIZE_W-1:0] eff_width, eff_height;

   always_comb begin
      eff_width = frame_width_ff;
      if (frame_width_ff == '0) eff_width = SIZE_W'(1);
      else if (32'(frame_width_ff) > MAX_WIDTH) eff_width = SIZE_W'(MAX_WIDTH);
      eff_height = frame_height_ff;
      if (frame_height_ff == '0) eff_height = SIZE_W'(1);
      else if (32'(frame_height_ff) > MAX_HEIGHT) eff_height = SIZE_W'(MAX_HEIGHT);
   end

   // item register
   fsa_pkg::req_type item_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch_item) item_ff <= req_data;
   end

   // raster position to pixel
   localparam int unsigned FRAC_SHIFT = fsa_pkg::FRAC_W;
   logic [MAP_W-1:0]            x_prod, y_prod;
   logic [MAP_W-FRAC_SHIFT-1:0] x_scaled, y_scaled;
   logic [SIZE_W-1:0]           map_col, map_row;

   assign x_prod   = MAP_W'(item_ff.raster_x) * MAP_W'(eff_width);
   assign y_prod   = MAP_W'(item_ff.raster_y) * MAP_W'(eff_height);
   assign x_scaled = x_prod[MAP_W-1:FRAC_SHIFT];
   assign y_scaled = y_prod[MAP_W-1:FRAC_SHIFT];

   always_comb begin
      map_col = x_scaled[SIZE_W-1:0];
      if (x_scaled >= (MAP_W-FRAC_SHIFT)'(eff_width)) map_col = eff_width - SIZE_W'(1);
      map_row = y_scaled[SIZE_W-1:0];
      if (y_scaled >= (MAP_W-FRAC_SHIFT)'(eff_height)) map_row = eff_height - SIZE_W'(1);
   end

   // item checks
   assign flags.op            = item_ff.operation;
   assign flags.position_bad  = (item_ff.raster_x > fsa_pkg::POS_ONE) ||
                                (item_ff.raster_y > fsa_pkg::POS_ONE);
   assign flags.pixel_outside = (SIZE_W'(item_ff.pixel_col) >= eff_width) ||
                                (SIZE_W'(item_ff.pixel_row) >= eff_height);

   // pixel coordinates, taken in decode
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;

   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         if (item_ff.operation == fsa_pkg::OP_READ) begin
            col_ff <= COL_W'(item_ff.pixel_col);
            row_ff <= ROW_W'(item_ff.pixel_row);
         end else begin
            col_ff <= COL_W'(map_col);
            row_ff <= ROW_W'(map_row);
         end
      end
   end

   // sweep counter for reset and clear
   logic [ADDR_W-1:0] wipe_addr_ff;

   assign flags.wipe_last = (wipe_addr_ff == ADDR_W'(DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         wipe_addr_ff <= '0;
      end else if (cmd.wipe) begin
         wipe_addr_ff <= flags.wipe_last ? '0 : wipe_addr_ff + ADDR_W'(1);
      end
   end

   // store access
   logic [ADDR_W-1:0]                         pixel_addr, mem_addr;
   logic                                      mem_we;
   sums_type                                  mem_wdata;
   sums_type                                  rd_ff;
   logic [NCH-1:0][fsa_pkg::COLOR_W-1:0]      colors;
   logic [SUM_W:0]                            acc_sum [NCH];

   assign pixel_addr = ADDR_W'(32'(row_ff) * MAX_WIDTH + 32'(col_ff));
   assign mem_addr   = cmd.wipe ? wipe_addr_ff : pixel_addr;
   assign mem_we     = cmd.wipe || cmd.store;
   assign colors     = {item_ff.blue_in, item_ff.green_in, item_ff.red_in};

   // overwrite or saturating add
   always_comb begin
      for (int j = 0; j < NCH; j++) begin
         acc_sum[j] = {1'b0, rd_ff[j]} + (SUM_W+1)'(colors[j]);
         if (cmd.wipe) begin
            mem_wdata[j] = '0;
         end else if (item_ff.operation == fsa_pkg::OP_RECORD) begin
            mem_wdata[j] = SUM_W'(colors[j]);
         end else begin
            mem_wdata[j] = acc_sum[j][SUM_W] ? '1 : acc_sum[j][SUM_W-1:0];
         end
      end
   end

   sums_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      if (cmd.mem_read) rd_ff <= mem[mem_addr];
   end

   // readout scale, clamped at 1.0
   logic [SCALE_W-1:0] scaled [NCH];
   logic [LEVEL_W-1:0] level_ff [NCH];

   always_comb begin
      for (int j = 0; j < NCH; j++) begin
         scaled[j] = SCALE_W'(rd_ff[j]) * SCALE_W'(readout_weight_ff);
      end
   end

   // gamma search: binary search over the threshold table, one step a cycle
   logic [BYTE_W-1:0] lo_ff [NCH];
   logic [BYTE_W-1:0] hi_ff [NCH];
   logic [BYTE_W-1:0] mid  [NCH];
   logic [BYTE_W:0]   mid_sum [NCH];
   logic [STEP_W-1:0] step_ff;

   assign flags.search_last = (step_ff == STEP_W'(SEARCH_STEPS - 1));

   always_comb begin
      for (int j = 0; j < NCH; j++) begin
         mid_sum[j] = (BYTE_W+1)'(lo_ff[j]) + (BYTE_W+1)'(hi_ff[j]) + (BYTE_W+1)'(1);
         mid[j]     = mid_sum[j][BYTE_W:1];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         step_ff <= '0;
         for (int j = 0; j < NCH; j++) begin
            level_ff[j] <= (scaled[j][SCALE_W-1:SUM_W] != '0) ? LEVEL_FULL
                                                              : {1'b0, scaled[j][SUM_W-1:0]};
            lo_ff[j] <= '0;
            hi_ff[j] <= BYTE_MAX;
         end
      end else if (cmd.search) begin
         step_ff <= step_ff + STEP_W'(1);
         for (int j = 0; j < NCH; j++) begin
            if (level_ff[j] >= fsa_pkg::GAMMA_THRESHOLD[mid[j]]) lo_ff[j] <= mid[j];
            else hi_ff[j] <= mid[j] - BYTE_W'(1);
         end
      end
   end

   // result register
   fsa_pkg::rsp_type rsp_ff;
   logic             is_write_op, is_read_op;

   assign is_write_op = (item_ff.operation == fsa_pkg::OP_RECORD) ||
                        (item_ff.operation == fsa_pkg::OP_ACCUMULATE);
   assign is_read_op  = (item_ff.operation == fsa_pkg::OP_READ);

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_ff.red_out   <= '0;
         rsp_ff.green_out <= '0;
         rsp_ff.blue_out  <= '0;
         if (is_write_op && flags.position_bad) begin
            rsp_ff.status <= fsa_pkg::STATUS_REJECTED;
         end else if (is_read_op && flags.pixel_outside) begin
            rsp_ff.status <= fsa_pkg::STATUS_OUTSIDE;
         end else begin
            rsp_ff.status <= fsa_pkg::STATUS_DONE;
            if (is_read_op) begin
               rsp_ff.red_out   <= lo_ff[0];
               rsp_ff.green_out <= lo_ff[1];
               rsp_ff.blue_out  <= lo_ff[2];
            end
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: rtl/film_splat_accumulator_gamma_readout.sv
// Accumulation film store with gamma 2.2 readout.
// Request channel (req_valid/req_ready/req_data) carries one item per beat:
// record or accumulate an RGB splat at a raster position, read a pixel, or
// clear the store. Every item returns exactly one beat on the response channel
// (rsp_valid/rsp_ready/rsp_data) with a status and, for reads, three bytes.
// Items are handled one at a time by a controller walking a single-port store;
// the response sits in an output register, so a stalled receiver holds one
// finished result while the next item is taken and worked on.
// From accept, a rejected or outside item goes straight from decode to finish;
// record adds a store, accumulate a fetch and a store, read a store read, scale
// multiply and an 8-step binary search of the gamma table, clear a full sweep.
// A new item is taken the cycle after the last one has loaded its result.
// Reset (synchronous) restores the registers and then sweeps the store to zero
// one entry a cycle, all MAX_WIDTH*MAX_HEIGHT entries (65536 by default), with
// req_ready low; the csr_ write port is taken at any time.
// If the receiver keeps rsp_ready low, the block stops before loading the
// next result and holds req_ready low until the register frees.
module film_splat_accumulator_gamma_readout #(
   parameter int unsigned MAX_WIDTH  = fsa_pkg::MAX_WIDTH_DEFAULT,
   parameter int unsigned MAX_HEIGHT = fsa_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  fsa_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output fsa_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write_enable,
   input  logic [fsa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fsa_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   fsa_pkg::cmd_type   cmd;
   fsa_pkg::flags_type flags;

   // sequencer
   fsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   // store, mapping and readout
   fsa_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .cmd              (cmd),
      .flags            (flags),
      .rsp_data         (rsp_data)
   );

endmodule

FILE: rtl/fsa_checker.sv
module fsa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input fsa_pkg::rsp_type  rsp_data
);

   // reset starts the sweep: nothing offered, nothing taken
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block not quiet after reset");

   // one item at a time: no accept right after an accept
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item taken while one is in work");

   // unused status code never shows
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == fsa_pkg::STATUS_DONE ||
                     rsp_data.status == fsa_pkg::STATUS_REJECTED ||
                     rsp_data.status == fsa_pkg::STATUS_OUTSIDE))
      else $error("bad status code");

   // failed items carry zero bytes
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != fsa_pkg::STATUS_DONE) |->
         (rsp_data.red_out == '0 && rsp_data.green_out == '0 && rsp_data.blue_out == '0))
      else $error("nonzero bytes on failed item");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

endmodule

bind film_splat_accumulator_gamma_readout fsa_checker u_fsa_checker (.*);

FILE: verif/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fsa_pkg::*;

   localparam int unsigned FILM_W = MAX_WIDTH_DEFAULT;
   localparam int unsigned FILM_H = MAX_HEIGHT_DEFAULT;

   // index 3 has no register behind it
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } film_pixel_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   req_type                req_data         = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;

   // shadow of the film store and registers
   film_pixel_type      film [FILM_W*FILM_H];
   logic [SIZE_W-1:0]   width_reg  = FRAME_WIDTH_RESET;
   logic [SIZE_W-1:0]   height_reg = FRAME_HEIGHT_RESET;
   logic [WEIGHT_W-1:0] weight_reg = READOUT_WEIGHT_RESET;

   // k^11 * 2^160: level^5 * 255^11 must reach this for byte k
   logic [255:0] gamma_knee [1:255];

   req_type      queued_items [$];
   rsp_type      expected_answers [$];
   logic [15:0]  touched_pixels [$];
   rsp_type      oldest_answer;
   int unsigned  beats_queued   = 0;
   int unsigned  beats_accepted = 0;
   int unsigned  error_count    = 0;
   int unsigned  burst_left     = 0;
   int unsigned  gap_left       = 0;
   int unsigned  stall_left     = 0;
   int unsigned  stall_mode     = 0;
   int unsigned  monitor_cycles = 0;

   film_splat_accumulator_gamma_readout u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      foreach (film[i]) film[i] = '0;
      for (int k = 1; k < 256; k++) begin
         gamma_knee[k] = 256'd1;
         for (int i = 0; i < 11; i++) gamma_knee[k] = gamma_knee[k] * 256'(k);
         gamma_knee[k] = gamma_knee[k] << 160;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned active_size(logic [SIZE_W-1:0] value, int unsigned limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   // floor(pos * size) in Q1.16, clamped to the last pixel
   function automatic int unsigned map_position(logic [POS_W-1:0] pos, int unsigned size);
      logic [31:0] spot;
      spot = (32'(pos) * 32'(size)) >> FRAC_W;
      if (spot > size - 1) spot = size - 1;
      return spot;
   endfunction

   function automatic logic [SUM_W-1:0] saturating_add(logic [SUM_W-1:0] sum,
                                                       logic [COLOR_W-1:0] color);
      logic [SUM_W:0] total;
      total = {1'b0, sum} + (SUM_W+1)'(color);
      return total[SUM_W] ? '1 : total[SUM_W-1:0];
   endfunction

   // count of k in 1..255 with (sum*weight/2^32) >= (k/255)^2.2, exact
   function automatic logic [BYTE_W-1:0] gamma_encode(logic [SUM_W-1:0] sum,
                                                     logic [WEIGHT_W-1:0] weight);
      logic [55:0]       level;
      logic [255:0]      power;
      logic [BYTE_W-1:0] code;
      level = 56'(sum) * 56'(weight);
      if (level == 0) return '0;
      if (level[55:32] != 0) return '1;
      power = 256'd1;
      for (int i = 0; i < 5; i++) power = power * 256'(level);
      for (int i = 0; i < 11; i++) power = power * 256'd255;
      code = '0;
      for (int k = 1; k < 256; k++) if (power >= gamma_knee[k]) code++;
      return code;
   endfunction

   // apply one accepted item to the shadow film and return its answer
   function automatic rsp_type apply_to_film(req_type item);
      rsp_type     answer;
      int unsigned cols;
      int unsigned rows;
      int unsigned spot;
      answer = '0;
      cols   = active_size(width_reg, FILM_W);
      rows   = active_size(height_reg, FILM_H);
      case (item.operation)
         OP_RECORD, OP_ACCUMULATE: begin
            if (item.raster_x > POS_ONE || item.raster_y > POS_ONE) begin
               answer.status = STATUS_REJECTED;
            end else begin
               spot = map_position(item.raster_y, rows) * FILM_W
                    + map_position(item.raster_x, cols);
               if (item.operation == OP_RECORD) begin
                  film[spot] = {SUM_W'(item.red_in), SUM_W'(item.green_in),
                                SUM_W'(item.blue_in)};
               end else begin
                  film[spot].red   = saturating_add(film[spot].red, item.red_in);
                  film[spot].green = saturating_add(film[spot].green, item.green_in);
                  film[spot].blue  = saturating_add(film[spot].blue, item.blue_in);
               end
            end
         end
         OP_READ: begin
            if (item.pixel_col >= cols || item.pixel_row >= rows) begin
               answer.status = STATUS_OUTSIDE;
            end else begin
               spot = item.pixel_row * FILM_W + item.pixel_col;
               answer.red_out   = gamma_encode(film[spot].red, weight_reg);
               answer.green_out = gamma_encode(film[spot].green, weight_reg);
               answer.blue_out  = gamma_encode(film[spot].blue, weight_reg);
            end
         end
         default: begin
            foreach (film[i]) film[i] = '0;
         end
      endcase
      return answer;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic logic [POS_W-1:0] random_position();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return '0;
      if (pick == 1) return POS_ONE;
      if (pick < 4) return POS_W'($urandom);
      return POS_W'($urandom_range(0, POS_ONE));
   endfunction

   function automatic logic [COLOR_W-1:0] random_color(bit heavy);
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (heavy && pick < 9) return COLOR_W'($urandom_range(24'hE00000, 24'hFFFFFF));
      if (pick < 2) return COLOR_W'($urandom_range(0, 255));
      if (pick < 6) return COLOR_W'($urandom_range(0, 65535));
      if (pick < 9) return COLOR_W'($urandom);
      return COLOR_W'($urandom_range(24'hF00000, 24'hFFFFFF));
   endfunction

   // heavy items pile large splats onto the store to drive sums into saturation
   function automatic req_type make_item(bit heavy);
      req_type     item;
      int unsigned cols;
      int unsigned rows;
      int unsigned pick;
      cols           = active_size(width_reg, FILM_W);
      rows           = active_size(height_reg, FILM_H);
      item.raster_x  = random_position();
      item.raster_y  = random_position();
      item.red_in    = random_color(heavy);
      item.green_in  = random_color(heavy);
      item.blue_in   = random_color(heavy);
      item.pixel_col = BYTE_W'($urandom);
      item.pixel_row = BYTE_W'($urandom);
      pick = $urandom_range(0, 19);
      if (heavy) begin
         if (pick < 14) item.operation = OP_ACCUMULATE;
         else if (pick < 19) item.operation = OP_READ;
         else item.operation = OP_RECORD;
      end else begin
         if (pick < 6) item.operation = OP_RECORD;
         else if (pick < 12) item.operation = OP_ACCUMULATE;
         else item.operation = OP_READ;
      end
      if (item.operation == OP_READ) begin
         // half the time, read back one of the pixels that were just splatted
         pick = $urandom_range(0, 9);
         if (pick < 5 && touched_pixels.size() > 0) begin
            {item.pixel_row, item.pixel_col} =
               touched_pixels[$urandom_range(0, touched_pixels.size() - 1)];
         end else if (pick < 8) begin
            item.pixel_col = BYTE_W'($urandom_range(0, cols - 1));
            item.pixel_row = BYTE_W'($urandom_range(0, rows - 1));
         end
      end else if (item.raster_x <= POS_ONE && item.raster_y <= POS_ONE) begin
         touched_pixels.push_back({BYTE_W'(map_position(item.raster_y, rows)),
                                   BYTE_W'(map_position(item.raster_x, cols))});
         if (touched_pixels.size() > 16) void'(touched_pixels.pop_front());
      end
      return item;
   endfunction

   function automatic req_type splat_item(op_type op, logic [POS_W-1:0] x,
                                          logic [POS_W-1:0] y, logic [COLOR_W-1:0] red,
                                          logic [COLOR_W-1:0] green,
                                          logic [COLOR_W-1:0] blue);
      req_type item;
      item           = '0;
      item.operation = op;
      item.raster_x  = x;
      item.raster_y  = y;
      item.red_in    = red;
      item.green_in  = green;
      item.blue_in   = blue;
      return item;
   endfunction

   function automatic req_type read_item(logic [BYTE_W-1:0] col, logic [BYTE_W-1:0] row);
      req_type item;
      item           = '0;
      item.operation = OP_READ;
      item.pixel_col = col;
      item.pixel_row = row;
      return item;
   endfunction

   task automatic queue_item(req_type item);
      queued_items.push_back(item);
      beats_queued++;
   endtask

   task automatic wait_drain();
      while (beats_accepted != beats_queued || expected_answers.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      case (index)
         CSR_FRAME_WIDTH:    width_reg  = value[SIZE_W-1:0];
         CSR_FRAME_HEIGHT:   height_reg = value[SIZE_W-1:0];
         CSR_READOUT_WEIGHT: weight_reg = value[WEIGHT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // set up the registers, then stream a batch and let it drain
   task automatic run_phase(logic [SIZE_W-1:0] cols, logic [SIZE_W-1:0] rows,
                            logic [WEIGHT_W-1:0] weight, int unsigned count,
                            bit heavy, bit with_clear);
      int unsigned clear_at;
      req_type     item;
      clear_at = with_clear ? $urandom_range(0, count - 1) : count;
      write_csr(CSR_FRAME_WIDTH, {15'($urandom), cols});
      write_csr(CSR_FRAME_HEIGHT, {15'($urandom), rows});
      write_csr(CSR_READOUT_WEIGHT, weight);
      @(negedge clock);
      touched_pixels.delete();
      for (int unsigned i = 0; i < count; i++) begin
         item = make_item(heavy);
         if (i == clear_at) item.operation = OP_CLEAR;
         queue_item(item);
      end
      wait_drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: corners, clamping, rejection, outside reads, clear
      run_phase(9'd200, 9'd100, 24'h010000, 0, 1'b0, 1'b0);
      queue_item(read_item(8'd0, 8'd0));
      queue_item(splat_item(OP_RECORD, '0, '0, 24'h010000, 24'h008000, 24'h000000));
      queue_item(read_item(8'd0, 8'd0));
      queue_item(splat_item(OP_ACCUMULATE, '0, '0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
      queue_item(read_item(8'd0, 8'd0));
      queue_item(splat_item(OP_RECORD, POS_ONE, POS_ONE, 24'h000001, 24'h000100,
                            24'h00FFFF));
      queue_item(read_item(8'd199, 8'd99));
      queue_item(splat_item(OP_RECORD, POS_ONE + 1, '0, 24'h010000, 24'h010000,
                            24'h010000));
      queue_item(splat_item(OP_ACCUMULATE, '0, '1, 24'h010000, 24'h010000, 24'h010000));
      queue_item(splat_item(OP_ACCUMULATE, '1, '1, 24'h010000, 24'h010000, 24'h010000));
      queue_item(splat_item(OP_RECORD, 17'h0FFFF, 17'h08000, 24'h004000, 24'h000010,
                            24'h7FFFFF));
      queue_item(read_item(8'd199, 8'd50));
      queue_item(read_item(8'd200, 8'd0));
      queue_item(read_item(8'd0, 8'd100));
      queue_item(read_item(8'hFF, 8'hFF));
      queue_item(splat_item(OP_CLEAR, '1, '1, '1, '1, '1));
      queue_item(read_item(8'd0, 8'd0));
      queue_item(read_item(8'd199, 8'd99));
      queue_item(splat_item(OP_ACCUMULATE, POS_ONE, '0, 24'h000001, 24'h000002,
                            24'h000003));
      queue_item(read_item(8'd199, 8'd0));
      wait_drain();

      // one pixel, big splats: ramp through the gamma curve into saturation
      run_phase(9'd1, 9'd1, 24'h000100, 260, 1'b1, 1'b0);
      // unit weight shows a saturated sum apart from a wrapped one
      run_phase(9'd1, 9'd1, 24'h000001, 40, 1'b1, 1'b0);
      write_csr(CSR_SPARE, CSR_DATA_W'($urandom));
      // zero and oversized frame sizes
      run_phase(9'd0, 9'h1FF, 24'hFFFFFF, 120, 1'b0, 1'b0);
      run_phase(9'h1FF, 9'd0, 24'h000000, 100, 1'b0, 1'b1);
      run_phase(9'd4, 9'd3, 24'h010000, 200, 1'b0, 1'b0);
      run_phase(9'd256, 9'd256, 24'h000400, 200, 1'b0, 1'b1);
      repeat (3) begin
         run_phase(SIZE_W'($urandom_range(1, 24)), SIZE_W'($urandom_range(1, 24)),
                   ($urandom_range(0, 1) == 0) ? WEIGHT_W'($urandom)
                                               : WEIGHT_W'($urandom_range(1, 24'h020000)),
                   110, 1'b0, 1'b0);
      end

      // results are all back; give the block a moment to show anything stray
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("film_splat_accumulator_gamma_readout test passed");
      end else begin
         $display("film_splat_accumulator_gamma_readout test failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("film_splat_accumulator_gamma_readout test failed");
      $finish;
   end

   // ---------------------------------------------------------------- driver
   // bursts of beats with random gaps; payload held until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left   = 0;
         burst_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_answers.push_back(apply_to_film(req_data));
            beats_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (queued_items.size() > 0) begin
               req_data  <= queued_items.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // compares each result beat with the oldest expectation; ready stalls in moods
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               $display("%0t ns: result beat with nothing expected, actual %p",
                        $time, rsp_data);
               error_count++;
            end else begin
               oldest_answer = expected_answers.pop_front();
               check_field("status", 8'(oldest_answer.status), 8'(rsp_data.status));
               check_field("red_out", oldest_answer.red_out, rsp_data.red_out);
               check_field("green_out", oldest_answer.green_out, rsp_data.green_out);
               check_field("blue_out", oldest_answer.blue_out, rsp_data.blue_out);
            end
         end
         monitor_cycles++;
         if (monitor_cycles % 300 == 0) stall_mode = $urandom_range(0, 2);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (stall_mode != 0 &&
                      $urandom_range(0, (stall_mode == 1) ? 15 : 2) == 0) begin
            stall_left = $urandom_range(0, 11);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

endmodule
